// ===== design/q4kdot_pkg.sv =====
// Shared types and constants for the Q4_K super-block dot product core.
package q4kdot_pkg;

  localparam int SUPERBLOCK_ELEMENTS = 256;
  localparam int BLOCK_BYTES = SUPERBLOCK_ELEMENTS / 2;
  localparam int POS_W = $clog2(BLOCK_BYTES);
  localparam int PACKED_COUNT = 12;
  localparam int IDX_W = 4;
  localparam int ACT_W = 16;
  localparam int MAIN_ACC_W = 35;
  localparam int MIN_ACC_W = 31;
  localparam int MAIN_OUT_W = 34;
  localparam int MIN_OUT_W = 30;
  localparam int IN_DATA_W = 56;
  localparam int OUT_DATA_W = 64;

  localparam logic CMD_SCALE = 1'b0;
  localparam logic CMD_WEIGHT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL1 = 4'b0010,
    ST_MUL2 = 4'b0100,
    ST_ACC  = 4'b1000
  } state_t;

  typedef struct packed {
    logic capture;
    logic load_scale;
    logic mul1;
    logic mul2;
    logic acc;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } ctrl_status_t;

endpackage

// ===== design/q4k_int16_superblock_dot.sv =====
// Top level of the Q4_K x int16 super-block dot product core.
// Scale byte transaction: loaded in the idle state, which stays ready for the next one. Weight byte transaction:
// steps through capture, scale*nibble multiply, activation multiply and accumulate; the result is
// registered at the accumulate step of the last byte. The output register holds a result while the
// next super-block streams in; a further last byte waits in accumulate until it is taken.
// rst (synchronous) clears accumulators, byte position and output valid; scale bytes are not reset.
module q4k_int16_superblock_dot (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // scale_index[3:0], scale_byte[11:4], weight_byte[19:12],
  // act_low[35:20], act_high[51:36], zero[55:52]
  input  logic [55:0] s_tdata,
  // cmd
  input  logic        s_tuser,
  // last_pair
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // main_sum[33:0], min_sum[63:34]
  output logic [63:0] m_tdata
);

  q4kdot_pkg::ctrl_cmd_t cmd;
  q4kdot_pkg::ctrl_status_t status;
  logic [q4kdot_pkg::MAIN_OUT_W-1:0] out_main;
  logic [q4kdot_pkg::MIN_OUT_W-1:0] out_min;

  q4kdot_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_cmd   (s_tuser),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  q4kdot_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .in_scale_index (s_tdata[3:0]),
    .in_scale_byte  (s_tdata[11:4]),
    .in_weight_byte (s_tdata[19:12]),
    .in_act_low     (s_tdata[35:20]),
    .in_act_high    (s_tdata[51:36]),
    .in_last        (s_tlast),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_main       (out_main),
    .out_min        (out_min)
  );

  assign m_tdata = {out_min, out_main};

endmodule

// ===== design/q4kdot_ctrl.sv =====
// Controller state machine sequencing capture, multiply and accumulate steps.
module q4kdot_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_cmd,
  output logic                    in_ready,
  input  q4kdot_pkg::ctrl_status_t status,
  output q4kdot_pkg::ctrl_cmd_t    cmd
);

  q4kdot_pkg::state_t state, state_next;
  logic accept;

  assign in_ready = (state == q4kdot_pkg::ST_IDLE);
  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      q4kdot_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_cmd == q4kdot_pkg::CMD_WEIGHT) begin
            cmd.capture = 1'b1;
            state_next = q4kdot_pkg::ST_MUL1;
          end else begin
            cmd.load_scale = 1'b1;
          end
        end
      end
      q4kdot_pkg::ST_MUL1: begin
        cmd.mul1 = 1'b1;
        state_next = q4kdot_pkg::ST_MUL2;
      end
      q4kdot_pkg::ST_MUL2: begin
        cmd.mul2 = 1'b1;
        state_next = q4kdot_pkg::ST_ACC;
      end
      q4kdot_pkg::ST_ACC: begin
        if (!status.last) begin
          cmd.acc = 1'b1;
          state_next = q4kdot_pkg::ST_IDLE;
        end else if (!status.out_busy) begin
          cmd.acc = 1'b1;
          cmd.emit = 1'b1;
          state_next = q4kdot_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = q4kdot_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= q4kdot_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/q4kdot_datapath.sv =====
// Datapath: scale store, unpack, two-step multiply, accumulators, output register.
module q4kdot_datapath (
  input  logic                                    clk,
  input  logic                                    rst,
  input  q4kdot_pkg::ctrl_cmd_t                   cmd,
  output q4kdot_pkg::ctrl_status_t                status,
  input  logic [q4kdot_pkg::IDX_W-1:0]            in_scale_index,
  input  logic [7:0]                              in_scale_byte,
  input  logic [7:0]                              in_weight_byte,
  input  logic signed [q4kdot_pkg::ACT_W-1:0]     in_act_low,
  input  logic signed [q4kdot_pkg::ACT_W-1:0]     in_act_high,
  input  logic                                    in_last,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [q4kdot_pkg::MAIN_OUT_W-1:0]       out_main,
  output logic [q4kdot_pkg::MIN_OUT_W-1:0]        out_min
);

  logic [7:0] packed_scales [q4kdot_pkg::PACKED_COUNT];
  logic [5:0] sub_scale [8];
  logic [5:0] sub_min [8];

  logic [7:0] weight;
  logic signed [q4kdot_pkg::ACT_W-1:0] act_lo, act_hi;
  logic last;
  logic [q4kdot_pkg::POS_W-1:0] byte_pos;
  logic [1:0] grp;

  logic [9:0] scn_lo, scn_hi;
  logic [5:0] mn_lo, mn_hi;
  logic signed [26:0] prod_lo, prod_hi;
  logic signed [22:0] mprod_lo, mprod_hi;

  logic [q4kdot_pkg::MAIN_ACC_W-1:0] main_acc, main_sum;
  logic [q4kdot_pkg::MIN_ACC_W-1:0] min_acc, min_sum;

  assign grp = byte_pos[q4kdot_pkg::POS_W-1 -: 2];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      sub_scale[j] = packed_scales[j][5:0];
      sub_min[j] = packed_scales[j + 4][5:0];
      sub_scale[j + 4] = {packed_scales[j][7:6], packed_scales[j + 8][3:0]};
      sub_min[j + 4] = {packed_scales[j + 4][7:6], packed_scales[j + 8][7:4]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_scale && (in_scale_index < q4kdot_pkg::IDX_W'(q4kdot_pkg::PACKED_COUNT))) begin
      packed_scales[in_scale_index] <= in_scale_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      weight <= in_weight_byte;
      act_lo <= in_act_low;
      act_hi <= in_act_high;
      last <= in_last;
    end
    if (cmd.mul1) begin
      scn_lo <= 10'(sub_scale[{grp, 1'b0}]) * 10'(weight[3:0]);
      scn_hi <= 10'(sub_scale[{grp, 1'b1}]) * 10'(weight[7:4]);
      mn_lo <= sub_min[{grp, 1'b0}];
      mn_hi <= sub_min[{grp, 1'b1}];
    end
    if (cmd.mul2) begin
      prod_lo <= $signed({1'b0, scn_lo}) * act_lo;
      prod_hi <= $signed({1'b0, scn_hi}) * act_hi;
      mprod_lo <= $signed({1'b0, mn_lo}) * act_lo;
      mprod_hi <= $signed({1'b0, mn_hi}) * act_hi;
    end
  end

  assign main_sum = main_acc
                  + {{(q4kdot_pkg::MAIN_ACC_W-27){prod_lo[26]}}, prod_lo}
                  + {{(q4kdot_pkg::MAIN_ACC_W-27){prod_hi[26]}}, prod_hi};
  assign min_sum = min_acc
                 + {{(q4kdot_pkg::MIN_ACC_W-23){mprod_lo[22]}}, mprod_lo}
                 + {{(q4kdot_pkg::MIN_ACC_W-23){mprod_hi[22]}}, mprod_hi};

  always_ff @(posedge clk) begin
    if (rst) begin
      main_acc <= '0;
      min_acc <= '0;
      byte_pos <= '0;
    end else if (cmd.acc) begin
      if (cmd.emit) begin
        main_acc <= '0;
        min_acc <= '0;
        byte_pos <= '0;
      end else begin
        main_acc <= main_sum;
        min_acc <= min_sum;
        byte_pos <= byte_pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_main <= main_sum[q4kdot_pkg::MAIN_OUT_W-1:0];
      out_min <= min_sum[q4kdot_pkg::MIN_OUT_W-1:0];
    end
  end

  assign status.last = last;
  assign status.out_busy = out_valid && !out_ready;

endmodule

// ===== tb/sv/tb_q4k_int16_superblock_dot.sv =====
// Self-checking testbench for the Q4_K x int16 super-block dot product core.
`timescale 1ns / 100ps

module tb_q4k_int16_superblock_dot;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 24;

  typedef struct {
    logic [q4kdot_pkg::MAIN_OUT_W-1:0] main_sum;
    logic [q4kdot_pkg::MIN_OUT_W-1:0]  min_sum;
  } block_sums_t;

  class superblock_sum_checker;
    logic [7:0]                        scale_bytes[q4kdot_pkg::PACKED_COUNT];
    logic [q4kdot_pkg::MAIN_ACC_W-1:0] main_acc;
    logic [q4kdot_pkg::MIN_ACC_W-1:0]  min_acc;
    logic [q4kdot_pkg::POS_W-1:0]      byte_pos;
    block_sums_t                       expected_sums[$];
    int                                mismatches;
    int                                blocks_closed;

    function new();
      foreach (scale_bytes[i]) scale_bytes[i] = 8'h00;
      main_acc = '0;
      min_acc = '0;
      byte_pos = '0;
      mismatches = 0;
      blocks_closed = 0;
    endfunction

    function int pending();
      return expected_sums.size();
    endfunction

    // Split layout: sub-blocks 0..3 use the low six bits directly, 4..7 borrow the top bits.
    function void add_element(int unsigned sub, logic [3:0] nib, logic signed [15:0] act);
      logic [5:0] sc;
      logic [5:0] mn;
      longint     prod;
      longint     mprod;
      if (sub < 4) begin
        sc = scale_bytes[sub][5:0];
        mn = scale_bytes[sub + 4][5:0];
      end else begin
        sc = {scale_bytes[sub - 4][7:6], scale_bytes[sub + 4][3:0]};
        mn = {scale_bytes[sub][7:6], scale_bytes[sub + 4][7:4]};
      end
      prod = longint'(sc) * longint'(nib) * longint'(act);
      mprod = longint'(mn) * longint'(act);
      main_acc = main_acc + prod[q4kdot_pkg::MAIN_ACC_W-1:0];
      min_acc = min_acc + mprod[q4kdot_pkg::MIN_ACC_W-1:0];
    endfunction

    function void note_transaction(logic cmd, logic [3:0] idx, logic [7:0] sbyte,
                                   logic [7:0] wbyte, logic signed [15:0] alo,
                                   logic signed [15:0] ahi, logic last);
      int unsigned grp;
      block_sums_t sums;
      if (cmd == q4kdot_pkg::CMD_SCALE) begin
        if (idx < q4kdot_pkg::PACKED_COUNT) scale_bytes[idx] = sbyte;
        return;
      end
      grp = byte_pos[q4kdot_pkg::POS_W-1:q4kdot_pkg::POS_W-2];
      add_element(2 * grp, wbyte[3:0], alo);
      add_element(2 * grp + 1, wbyte[7:4], ahi);
      byte_pos = byte_pos + 1'b1;
      if (last) begin
        sums.main_sum = main_acc[q4kdot_pkg::MAIN_OUT_W-1:0];
        sums.min_sum = min_acc[q4kdot_pkg::MIN_OUT_W-1:0];
        expected_sums.push_back(sums);
        main_acc = '0;
        min_acc = '0;
        byte_pos = '0;
        blocks_closed++;
      end
    endfunction

    function void flag(string what, longint exp_v, longint got_v);
      if (mismatches < 10)
        $display("mismatch %s: expected %0d got %0d", what, exp_v, got_v);
      mismatches++;
    endfunction

    function void check_result(logic [q4kdot_pkg::OUT_DATA_W-1:0] data);
      block_sums_t exp_s;
      logic [q4kdot_pkg::MAIN_OUT_W-1:0] got_main;
      logic [q4kdot_pkg::MIN_OUT_W-1:0]  got_min;
      got_main = data[q4kdot_pkg::MAIN_OUT_W-1:0];
      got_min = data[q4kdot_pkg::OUT_DATA_W-1:q4kdot_pkg::MAIN_OUT_W];
      if (expected_sums.size() == 0) begin
        flag("unexpected result main_sum", 0, longint'($signed(got_main)));
        return;
      end
      exp_s = expected_sums.pop_front();
      if (got_main !== exp_s.main_sum)
        flag("main_sum", longint'($signed(exp_s.main_sum)), longint'($signed(got_main)));
      if (got_min !== exp_s.min_sum)
        flag("min_sum", longint'($signed(exp_s.min_sum)), longint'($signed(got_min)));
    endfunction
  endclass

  logic                                 clk;
  logic                                 rst = 1'b1;
  logic                                 s_tvalid = 1'b0;
  logic                                 s_tready;
  logic [q4kdot_pkg::IN_DATA_W-1:0]     s_tdata = '0;
  logic                                 s_tuser = 1'b0;
  logic                                 s_tlast = 1'b0;
  logic                                 m_tvalid;
  logic                                 m_tready = 1'b0;
  logic [q4kdot_pkg::OUT_DATA_W-1:0]    m_tdata;

  superblock_sum_checker sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int cycle_count = 0;

  q4k_int16_superblock_dot dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  function automatic logic [15:0] rand_act();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_weight();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h0f;
      3: return 8'hf0;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_scale();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(logic cmd, logic [3:0] idx, logic [7:0] sbyte, logic [7:0] wbyte,
                           logic [15:0] alo, logic [15:0] ahi, logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tlast <= last;
    s_tdata <= {4'b0, ahi, alo, wbyte, sbyte, idx};
    do @(posedge clk); while (!s_tready);
    sb.note_transaction(cmd, idx, sbyte, wbyte, alo, ahi, last);
    if (cmd == q4kdot_pkg::CMD_WEIGHT || idx < q4kdot_pkg::PACKED_COUNT) items_sent++;
    @(negedge clk);
  endtask

  task automatic send_scale(logic [3:0] idx, logic [7:0] val, logic last);
    send_item(q4kdot_pkg::CMD_SCALE, idx, val, 8'($urandom), rand_act(), rand_act(), last);
  endtask

  task automatic send_weight(logic [7:0] wbyte, logic [15:0] alo, logic [15:0] ahi,
                             logic last);
    send_item(q4kdot_pkg::CMD_WEIGHT, 4'($urandom), 8'($urandom), wbyte, alo, ahi, last);
  endtask

  task automatic stream_weights(int count, bit close);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 63) == 0)
        send_scale(4'($urandom_range(0, q4kdot_pkg::PACKED_COUNT - 1)), rand_scale(),
                   1'($urandom));
      send_weight(rand_weight(), rand_act(), rand_act(), close && (i == count - 1));
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_random_traffic(int item_goal, int result_goal);
    int start_items;
    int start_blocks;
    int kind;
    logic [15:0] act;
    start_items = items_sent;
    start_blocks = sb.blocks_closed;
    while (items_sent - start_items < item_goal ||
           sb.blocks_closed - start_blocks < result_goal) begin
      kind = $urandom_range(0, 19);
      if (kind < 9) begin
        if ($urandom_range(0, 3) != 0)
          for (int i = 0; i < q4kdot_pkg::PACKED_COUNT; i++)
            send_scale(4'(i), rand_scale(), 1'($urandom));
        stream_weights(q4kdot_pkg::BLOCK_BYTES, 1'b1);
      end else if (kind < 15) begin
        stream_weights($urandom_range(1, 40), 1'b1);
      end else if (kind < 17) begin
        // runs past the block length so the byte position wraps
        stream_weights($urandom_range(q4kdot_pkg::BLOCK_BYTES + 1,
                                      q4kdot_pkg::BLOCK_BYTES + 72), 1'b1);
      end else if (kind == 17) begin
        act = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
        for (int i = 0; i < q4kdot_pkg::PACKED_COUNT; i++) send_scale(4'(i), 8'hff, 1'b0);
        for (int i = 0; i < q4kdot_pkg::BLOCK_BYTES; i++)
          send_weight(8'hff, act, act, i == q4kdot_pkg::BLOCK_BYTES - 1);
      end else begin
        repeat ($urandom_range(1, 4))
          send_scale(4'($urandom_range(0, 15)), rand_scale(), 1'($urandom));
        stream_weights($urandom_range(1, 20), 1'b0);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_scale(4'd0, 8'hff, 1'b0);
    send_scale(4'd1, 8'h00, 1'b0);
    send_scale(4'd2, 8'hc0, 1'b0);
    send_scale(4'd3, 8'h3f, 1'b0);
    send_scale(4'd4, 8'hff, 1'b0);
    send_scale(4'd5, 8'haa, 1'b0);
    send_scale(4'd6, 8'h55, 1'b0);
    send_scale(4'd7, 8'h81, 1'b0);
    send_scale(4'd8, 8'hff, 1'b0);
    send_scale(4'd9, 8'h0f, 1'b0);
    send_scale(4'd10, 8'hf0, 1'b0);
    send_scale(4'd11, 8'h7e, 1'b0);
    // out-of-range index, and last on a scale load: both ignored
    send_scale(4'd12, 8'h00, 1'b0);
    send_scale(4'd15, 8'h00, 1'b1);
    send_weight(8'hff, 16'h8000, 16'h8000, 1'b0);
    send_weight(8'hff, 16'h7fff, 16'h7fff, 1'b1);
    send_weight(8'h00, 16'h8000, 16'h7fff, 1'b1);
    send_weight(8'hf0, 16'hffff, 16'h0001, 1'b0);
    // scale change in the middle of a block
    send_scale(4'd3, 8'h00, 1'b1);
    send_weight(8'h0f, 16'h8000, 16'h7fff, 1'b1);
    send_weight(8'h5a, 16'h0000, 16'h0000, 1'b1);
    wait_drained();

    run_random_traffic(500, 12);
    wait_drained();
    send_idle_pct = 80;
    run_random_traffic(500, 12);
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 80;
    run_random_traffic(500, 12);
    wait_drained();
    send_idle_pct = 12;
    recv_stall_pct = 12;
    run_random_traffic(500, 12);
    wait_drained();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== q4k_int16_superblock_dot.f =====
design/q4kdot_pkg.sv
design/q4kdot_ctrl.sv
design/q4kdot_datapath.sv
design/q4k_int16_superblock_dot.sv
tb/sv/tb_q4k_int16_superblock_dot.sv
